[src/irlm_pkg.sv]
// ----------------------------------------------------------------------------
// irlm_pkg: shared types and constants of the I/Q RSSI level meter
// Item structs, the power-to-level table and the block geometry.
// ----------------------------------------------------------------------------
package irlm_pkg;

  localparam int unsigned SAMPLES_PER_BLOCK = 8;
  localparam int unsigned SAMPLE_W          = 32;
  localparam int unsigned POWER_W           = 32;
  localparam int unsigned LEVEL_W           = 8;
  localparam int unsigned SMOOTH_W          = 16;
  localparam int unsigned SUM_W             = 18;
  localparam int unsigned COUNT_W           = 10;
  localparam int unsigned LUT_IDX_W         = 5;
  localparam int unsigned AVG_SHIFT         = 3;   // divide by eight samples
  localparam int unsigned LUT_SHIFT         = 6;

  // average >= 2048 saturates the table index
  localparam int unsigned SAT_BIT = 11 + AVG_SHIFT;

  localparam logic [COUNT_W-1:0] DEFAULT_REPORT_PERIOD = COUNT_W'(50);
  localparam logic [LEVEL_W-1:0] TRACK_MIN_RESET       = LEVEL_W'(255);
  localparam logic [LUT_IDX_W-1:0] LUT_IDX_SAT         = LUT_IDX_W'(31);

  localparam logic [LEVEL_W-1:0] LEVEL_TABLE [32] = '{
    8'd0,   8'd101, 8'd130, 8'd148, 8'd161, 8'd171, 8'd179, 8'd186,
    8'd192, 8'd197, 8'd202, 8'd206, 8'd210, 8'd213, 8'd217, 8'd220,
    8'd222, 8'd225, 8'd227, 8'd230, 8'd232, 8'd234, 8'd236, 8'd238,
    8'd240, 8'd241, 8'd243, 8'd244, 8'd246, 8'd247, 8'd249, 8'd255
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample0;
    logic [SAMPLE_W-1:0] sample1;
    logic [SAMPLE_W-1:0] sample2;
    logic [SAMPLE_W-1:0] sample3;
    logic [SAMPLE_W-1:0] sample4;
    logic [SAMPLE_W-1:0] sample5;
    logic [SAMPLE_W-1:0] sample6;
    logic [SAMPLE_W-1:0] sample7;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [SUM_W-1:0]   level_sum;
    logic [COUNT_W-1:0] level_count;
  } out_item_t;

  // level stage to tracker stage
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } level_t;

endpackage

[src/iq_rssi_level_meter_top.sv]
// ----------------------------------------------------------------------------
// iq_rssi_level_meter_top: RSSI level meter for blocks of packed I/Q samples
// Each input item is eight packed samples (I in bits 15:0, Q in 31:16, both
// signed). The block power is mapped to a 0..255 level, which feeds an IIR
// smoother and decaying min/max trackers. After report_period items one
// report item (min, max, smoothed level sum, count) is emitted.
//
// Channels: in_* and out_* are valid/ready; an item moves when both are high.
// cfg_we_i writes report_period from cfg_wdata_i at once; write it only
// while no item is in flight.
// A report reaches out_valid_o from the item that closes the period through
// the input, power and level registers, then the tracker writes the output
// register.
// Throughput: one item per cycle while no waiting report holds the stages;
// the pipeline has no loop besides the tracker update.
// Reset: trackers, sum and count clear, min tracker to 255, report_period
// to 50, pipeline empty.
// Stall: a waiting report holds only items that would close the next
// period; other items keep moving, then back-pressure fills the stages.
// ----------------------------------------------------------------------------
module iq_rssi_level_meter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  irlm_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output irlm_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [irlm_pkg::COUNT_W-1:0]  cfg_wdata_i
);

  irlm_pkg::level_t level;
  logic             level_ready;

  irlm_power u_power (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .level_o       (level),
    .level_ready_i (level_ready)
  );

  irlm_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .level_i       (level),
    .level_ready_o (level_ready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule

[src/irlm_power.sv]
// ----------------------------------------------------------------------------
// irlm_power: block power and level front end
// Input register, eight squarers into a power register, then the wrapping
// block sum and table lookup into the level register.
// ----------------------------------------------------------------------------
module irlm_power (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  irlm_pkg::in_item_t  in_item_i,
  output irlm_pkg::level_t    level_o,
  input  logic                level_ready_i
);

  logic                                  in_valid_q;
  irlm_pkg::in_item_t                    in_q;
  logic                                  pwr_valid_q;
  logic [irlm_pkg::POWER_W-1:0]          pwr_q [irlm_pkg::SAMPLES_PER_BLOCK];
  logic [irlm_pkg::POWER_W-1:0]          pwr_d [irlm_pkg::SAMPLES_PER_BLOCK];
  logic                                  lvl_valid_q;
  logic [irlm_pkg::LEVEL_W-1:0]          lvl_q;
  logic [irlm_pkg::LEVEL_W-1:0]          lvl_d;
  logic [irlm_pkg::SAMPLE_W-1:0]         smp [irlm_pkg::SAMPLES_PER_BLOCK];
  logic [irlm_pkg::POWER_W-1:0]          sum_a [4];
  logic [irlm_pkg::POWER_W-1:0]          sum_b [2];
  logic [irlm_pkg::POWER_W-1:0]          total;
  logic [irlm_pkg::LUT_IDX_W-1:0]        lut_idx;
  logic                                  lvl_ready;
  logic                                  pwr_ready;

  assign lvl_ready  = !lvl_valid_q || level_ready_i;
  assign pwr_ready  = !pwr_valid_q || lvl_ready;
  assign in_ready_o = !in_valid_q || pwr_ready;

  always_comb begin
    smp[0] = in_q.sample0;
    smp[1] = in_q.sample1;
    smp[2] = in_q.sample2;
    smp[3] = in_q.sample3;
    smp[4] = in_q.sample4;
    smp[5] = in_q.sample5;
    smp[6] = in_q.sample6;
    smp[7] = in_q.sample7;
  end

  for (genvar k = 0; k < irlm_pkg::SAMPLES_PER_BLOCK; k++) begin : g_sq
    logic signed [15:0]                 i_s;
    logic signed [15:0]                 q_s;
    logic signed [irlm_pkg::POWER_W-1:0] ii;
    logic signed [irlm_pkg::POWER_W-1:0] qq;
    assign i_s = smp[k][15:0];
    assign q_s = smp[k][31:16];
    assign ii  = irlm_pkg::POWER_W'(i_s) * irlm_pkg::POWER_W'(i_s);
    assign qq  = irlm_pkg::POWER_W'(q_s) * irlm_pkg::POWER_W'(q_s);
    assign pwr_d[k] = $unsigned(ii) + $unsigned(qq);
  end

  // wrapping 32-bit adder tree
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum_a[j] = pwr_q[2*j] + pwr_q[2*j+1];
    end
    sum_b[0] = sum_a[0] + sum_a[1];
    sum_b[1] = sum_a[2] + sum_a[3];
    total    = sum_b[0] + sum_b[1];
    if (|total[irlm_pkg::POWER_W-1:irlm_pkg::SAT_BIT]) begin
      lut_idx = irlm_pkg::LUT_IDX_SAT;
    end else begin
      lut_idx = total[irlm_pkg::SAT_BIT-1:irlm_pkg::AVG_SHIFT+irlm_pkg::LUT_SHIFT];
    end
    lvl_d = irlm_pkg::LEVEL_TABLE[lut_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pwr_valid_q <= 1'b0;
      lvl_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (pwr_ready) begin
        pwr_valid_q <= in_valid_q;
      end
      if (lvl_ready) begin
        lvl_valid_q <= pwr_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (pwr_ready && in_valid_q) begin
      pwr_q <= pwr_d;
    end
    if (lvl_ready && pwr_valid_q) begin
      lvl_q <= lvl_d;
    end
  end

  assign level_o.valid = lvl_valid_q;
  assign level_o.level = lvl_q;

endmodule

[src/irlm_track.sv]
// ----------------------------------------------------------------------------
// irlm_track: level trackers and report register
// IIR smoother, decaying min/max, period sum and count, report period
// register and the output item register.
// ----------------------------------------------------------------------------
module irlm_track (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  irlm_pkg::level_t                 level_i,
  output logic                             level_ready_o,
  input  logic                             cfg_we_i,
  input  logic [irlm_pkg::COUNT_W-1:0]     cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output irlm_pkg::out_item_t              out_item_o
);

  logic [irlm_pkg::COUNT_W-1:0]  period_q;
  logic [irlm_pkg::SMOOTH_W-1:0] smooth_q, smooth_d;
  logic [irlm_pkg::LEVEL_W-1:0]  min_q, min_d;
  logic [irlm_pkg::LEVEL_W-1:0]  max_q, max_d;
  logic [irlm_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [irlm_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                          out_valid_q;
  irlm_pkg::out_item_t           out_q;
  logic [irlm_pkg::LEVEL_W-1:0]  lvl;
  logic [19:0]                   iir_acc;
  logic                          report;
  logic                          go;

  assign lvl = level_i.level;

  always_comb begin
    if (lvl < min_q) begin
      min_d = lvl;
    end else begin
      min_d = min_q + ((lvl - min_q) >> 4);
    end
    if (lvl > max_q) begin
      max_d = lvl;
    end else begin
      max_d = max_q - ((max_q - lvl) >> 4);
    end
    // (level << 8) + 7 * smooth, then >> 3
    iir_acc  = {4'd0, lvl, 8'd0} + {1'b0, smooth_q, 3'd0} - {4'd0, smooth_q};
    smooth_d = iir_acc[18:3];
    sum_d    = sum_q + irlm_pkg::SUM_W'(smooth_d[15:8]);
    count_d  = count_q + irlm_pkg::COUNT_W'(1);
    report   = count_d >= period_q;
  end

  assign go            = level_i.valid && (!report || !out_valid_q || out_ready_i);
  assign level_ready_o = go || !level_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= irlm_pkg::DEFAULT_REPORT_PERIOD;
      smooth_q    <= '0;
      min_q       <= irlm_pkg::TRACK_MIN_RESET;
      max_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (go) begin
        smooth_q <= smooth_d;
        min_q    <= min_d;
        max_q    <= max_d;
        if (report) begin
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          sum_q   <= sum_d;
          count_q <= count_d;
        end
      end
      if (go && report) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && report) begin
      out_q.min_level   <= min_d;
      out_q.max_level   <= max_d;
      out_q.level_sum   <= sum_d;
      out_q.level_count <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_clear_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && report |=> count_q == '0 && sum_q == '0)
    else $error("period sum/count not cleared after report");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && level_i.valid && report |-> !go)
    else $error("pending report overwritten");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.level_count != '0)
    else $error("report with zero count");

  a_report_reaches_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && report |=> out_valid_q && out_q.level_count >= $past(period_q))
    else $error("report emitted below period");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for iq_rssi_level_meter_top
// Feeds sample blocks through a bursty valid/ready sender and collects reports
// through a stalling receiver. A local copy of the level meter (power, log
// lookup, IIR smoother, min/max trackers, period sum) predicts every report,
// and the monitor checks each one field by field. report_period is rewritten
// between phases, including zero, one, the maximum and mid-period lowering.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [7:0] LEVEL_LUT [32] = '{
    8'd0,   8'd101, 8'd130, 8'd148, 8'd161, 8'd171, 8'd179, 8'd186,
    8'd192, 8'd197, 8'd202, 8'd206, 8'd210, 8'd213, 8'd217, 8'd220,
    8'd222, 8'd225, 8'd227, 8'd230, 8'd232, 8'd234, 8'd236, 8'd238,
    8'd240, 8'd241, 8'd243, 8'd244, 8'd246, 8'd247, 8'd249, 8'd255
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  irlm_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  irlm_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [irlm_pkg::COUNT_W-1:0]  cfg_wdata = '0;
  logic                          in_taken = 1'b0;

  // predicted meter state
  logic [15:0]                   smooth_q8 = '0;
  logic [7:0]                    min_trk = 8'd255;
  logic [7:0]                    max_trk = '0;
  logic [irlm_pkg::SUM_W-1:0]    sum_acc = '0;
  logic [irlm_pkg::COUNT_W-1:0]  cnt_acc = '0;
  logic [irlm_pkg::COUNT_W-1:0]  period_reg = 10'd50;

  irlm_pkg::in_item_t            block_queue[$];
  irlm_pkg::out_item_t           expected_reports[$];
  int                            mismatches = 0;
  int                            reports_seen = 0;
  int                            burst_left = 0;
  int                            gap_left = 0;
  int                            rdy_left = 0;

  iq_rssi_level_meter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic track_block(input irlm_pkg::in_item_t blk);
    logic [31:0]         words [irlm_pkg::SAMPLES_PER_BLOCK];
    logic [31:0]         total;
    logic [31:0]         avg;
    logic signed [15:0]  i_c;
    logic signed [15:0]  q_c;
    logic signed [31:0]  ii;
    logic signed [31:0]  qq;
    logic [4:0]          idx;
    logic [7:0]          lvl;
    logic [31:0]         acc;
    irlm_pkg::out_item_t rep;
    words = '{blk.sample0, blk.sample1, blk.sample2, blk.sample3,
              blk.sample4, blk.sample5, blk.sample6, blk.sample7};
    total = '0;
    for (int k = 0; k < irlm_pkg::SAMPLES_PER_BLOCK; k++) begin
      i_c = words[k][15:0];
      q_c = words[k][31:16];
      ii = 32'(i_c) * 32'(i_c);
      qq = 32'(q_c) * 32'(q_c);
      total = total + 32'(ii) + 32'(qq);
    end
    avg = total >> 3;
    idx = (avg >= 32'd2048) ? 5'd31 : avg[10:6];
    lvl = LEVEL_LUT[idx];

    if (lvl < min_trk) begin
      min_trk = lvl;
    end else begin
      min_trk = min_trk + ((lvl - min_trk) >> 4);
    end

    acc = (32'(lvl) << 8) + 32'd7 * 32'(smooth_q8);
    smooth_q8 = 16'(acc >> 3);

    if (lvl > max_trk) begin
      max_trk = lvl;
    end else begin
      max_trk = max_trk - ((max_trk - lvl) >> 4);
    end

    sum_acc = sum_acc + irlm_pkg::SUM_W'(smooth_q8[15:8]);
    cnt_acc = cnt_acc + irlm_pkg::COUNT_W'(1);
    if (cnt_acc >= period_reg) begin
      rep.min_level   = min_trk;
      rep.max_level   = max_trk;
      rep.level_sum   = sum_acc;
      rep.level_count = cnt_acc;
      expected_reports.push_back(rep);
      sum_acc = '0;
      cnt_acc = '0;
    end
  endtask

  // first n samples carry (i, q), the rest are zero
  function automatic irlm_pkg::in_item_t burst_of(input logic [15:0] i,
                                                  input logic [15:0] q,
                                                  input int n);
    logic [31:0] w [8];
    for (int k = 0; k < 8; k++) begin
      w[k] = (k < n) ? {q, i} : 32'h0;
    end
    return {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  endfunction

  function automatic logic [15:0] rand_comp(input int cls);
    logic [15:0] mag;
    case (cls)
      0: mag = 16'($urandom_range(0, 12));
      1: mag = 16'($urandom_range(0, 48));
      2: mag = 16'($urandom_range(0, 300));
      3: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'hffff;
          default: return 16'h0000;
        endcase
      end
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic irlm_pkg::in_item_t random_block(input int regime);
    logic [31:0] w [8];
    int          cls;
    for (int k = 0; k < 8; k++) begin
      cls = ($urandom_range(0, 3) != 0) ? regime : $urandom_range(0, 4);
      w[k] = {rand_comp(cls), rand_comp(cls)};
    end
    return {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  endfunction

  task automatic queue_random(input int n);
    int regime;
    regime = $urandom_range(0, 4);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) regime = $urandom_range(0, 4);
      block_queue.push_back(random_block(regime));
    end
  endtask

  task automatic drain;
    int waited;
    waited = 0;
    while ((block_queue.size() > 0 || in_valid || expected_reports.size() > 0) &&
           waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_reports.size() > 0) begin
      note_mismatch($sformatf("%0d expected reports never arrived",
                              expected_reports.size()));
      expected_reports.delete();
    end
  endtask

  task automatic set_period(input logic [irlm_pkg::COUNT_W-1:0] p);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    period_reg = p;
  endtask

  task automatic run_phase(input logic [irlm_pkg::COUNT_W-1:0] p, input int n);
    set_period(p);
    queue_random(n);
    drain();
  endtask

  // sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (block_queue.size() > 0) begin
        in_item  <= block_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 24);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: alternating stall and ready stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (rdy_left > 0) begin
      rdy_left--;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      rdy_left = $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
      rdy_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(0, 12);
    end
  end

  always @(posedge clk_i) begin
    irlm_pkg::out_item_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) track_block(in_item);
      if (out_valid && out_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          note_mismatch($sformatf("report %0d arrived with none expected", reports_seen));
        end else begin
          want = expected_reports.pop_front();
          if (out_item.min_level !== want.min_level)
            note_mismatch($sformatf("report %0d min_level got %0d want %0d",
                                    reports_seen, out_item.min_level, want.min_level));
          if (out_item.max_level !== want.max_level)
            note_mismatch($sformatf("report %0d max_level got %0d want %0d",
                                    reports_seen, out_item.max_level, want.max_level));
          if (out_item.level_sum !== want.level_sum)
            note_mismatch($sformatf("report %0d level_sum got %0d want %0d",
                                    reports_seen, out_item.level_sum, want.level_sum));
          if (out_item.level_count !== want.level_count)
            note_mismatch($sformatf("report %0d level_count got %0d want %0d",
                                    reports_seen, out_item.level_count,
                                    want.level_count));
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed blocks at the reset period of 50
    block_queue.push_back(burst_of(16'h0000, 16'h0000, 8));
    block_queue.push_back(burst_of(16'h8000, 16'h8000, 8));  // sum wraps to zero
    block_queue.push_back(burst_of(16'h8000, 16'h8000, 1));  // 2^31, saturates
    block_queue.push_back(burst_of(16'h8000, 16'h8000, 2));  // 2^32 wraps
    block_queue.push_back(burst_of(16'h8000, 16'h8000, 3));
    block_queue.push_back(burst_of(16'h7fff, 16'h7fff, 8));
    block_queue.push_back(burst_of(16'h8000, 16'h0000, 8));
    block_queue.push_back(burst_of(16'hffff, 16'hffff, 8));
    block_queue.push_back(burst_of(16'd22, 16'd0, 1));
    block_queue.push_back(burst_of(16'd23, 16'd0, 1));
    block_queue.push_back(burst_of(16'd127, 16'd0, 1));
    block_queue.push_back(burst_of(16'd128, 16'd0, 1));
    block_queue.push_back(burst_of(16'd0, 16'hff80, 1));
    block_queue.push_back(burst_of(16'h7fff, 16'h8000, 4));
    block_queue.push_back('1);
    block_queue.push_back({8{32'haaaa5555}});
    block_queue.push_back({8{32'h5555aaaa}});
    block_queue.push_back(burst_of(16'd16, 16'd16, 8));
    block_queue.push_back(burst_of(16'd45, 16'd0, 8));
    block_queue.push_back(burst_of(16'd46, 16'd0, 8));
    queue_random(40);
    drain();

    run_phase(10'd3, 60);     // lowered below the running count
    run_phase(10'd0, 40);
    run_phase(10'd1, 40);
    run_phase(10'd1023, 120);
    run_phase(10'd7, 80);
    for (int ph = 0; ph < 6; ph++) begin
      run_phase(10'($urandom_range(2, 40)), 60);
    end
    run_phase(10'($urandom_range(1, 5)), 190);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
